[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is off while reset is applied.
`define U2G_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define U2G_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/u2g_pkg.sv]
// Types, constants and glyph lookup for the UTF-8 glyph index decoder.
package u2g_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned SetW   = 2;
  localparam int unsigned IndexW = 7;

  localparam logic [SetW-1:0] GLYPH_ASCII = 2'd0;
  localparam logic [SetW-1:0] GLYPH_UPPER = 2'd1;
  localparam logic [SetW-1:0] GLYPH_LOWER = 2'd2;

  localparam logic [ByteW-1:0] LEAD3_MASK = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [ByteW-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [ByteW-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [ByteW-1:0] LEAD4_MASK_HI = 8'hF0;
  localparam logic [ByteW-1:0] LEAD4_CODE = 8'hF0;

  localparam logic [CpW-1:0]    QMARK_CP    = 21'h00003F;
  localparam logic [IndexW-1:0] QMARK_INDEX = 7'd31;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [SetW-1:0]   glyph_set;
    logic [IndexW-1:0] glyph_index;
    logic              glyph_found;
    logic              bad_lead;
  } result_t;

  function automatic result_t map_glyph(input logic [CpW-1:0] cp, input logic bad);
    result_t r;
    r.code_point  = cp;
    r.glyph_set   = GLYPH_ASCII;
    r.glyph_index = '0;
    r.glyph_found = 1'b1;
    r.bad_lead    = bad;
    if (cp inside {[21'd32:21'd126]}) begin
      r.glyph_index = cp[IndexW-1:0] - 7'd32;
    end else if (cp inside {[21'h000410:21'h00042F]}) begin
      r.glyph_set   = GLYPH_UPPER;
      r.glyph_index = {1'b0, cp[5:0]} - 7'd16;
    end else if (cp inside {[21'h000430:21'h00043F]}) begin
      r.glyph_set   = GLYPH_LOWER;
      r.glyph_index = {3'b000, cp[3:0]};
    end else if (cp inside {[21'h000440:21'h00044F]}) begin
      r.glyph_set   = GLYPH_LOWER;
      r.glyph_index = {3'b001, cp[3:0]};
    end else begin
      r.glyph_found = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/u2g_ifs.sv]
// Valid/ready channel interfaces for text bytes and glyph results.
interface u2g_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u2g_pkg::ByteW-1:0]    text_byte;

  modport source(output valid, output text_byte, input ready);
  modport sink(input valid, input text_byte, output ready);
endinterface

interface u2g_glyph_if;
  logic                         valid;
  logic                         ready;
  logic [u2g_pkg::CpW-1:0]      code_point;
  logic [u2g_pkg::SetW-1:0]     glyph_set;
  logic [u2g_pkg::IndexW-1:0]   glyph_index;
  logic                         glyph_found;
  logic                         bad_lead;

  modport source(output valid, output code_point, output glyph_set, output glyph_index,
                 output glyph_found, output bad_lead, input ready);
  modport sink(input valid, input code_point, input glyph_set, input glyph_index,
               input glyph_found, input bad_lead, output ready);
endinterface

[hdl/utf8_to_glyph_index_decoder_top.sv]
// UTF-8 byte stream decoder: emits code points with their font table and entry index.
//
// text_i carries one byte of UTF-8 text per item; glyph_o carries one decoded
// character per item. Both use valid/ready and move an item when both are high.
// A one-byte character or a bad lead byte gives a result for that byte; a
// multi-byte sequence gives one result on its last byte and none before.
// The last byte of a character is loaded into the input register, and its result
// then into the result register; the single decode step lies between the two.
// Throughput: one byte per cycle unless glyph_o stalls, set by that decode step.
// A stalled receiver holds the result register; the input register still takes
// one more byte, then text_i.ready drops until the result is taken.
// Reset clears both valid flags, the pending count and the partial code point.
module utf8_to_glyph_index_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  u2g_byte_if.sink    text_i,
  u2g_glyph_if.source glyph_o
);

  logic                          in_valid_q;
  logic [u2g_pkg::ByteW-1:0]     in_byte_q;
  logic [1:0]                    pend_q, pend_d;
  logic [u2g_pkg::CpW-1:0]       part_q, part_d;
  logic                          out_valid_q, out_valid_d;
  u2g_pkg::result_t              out_q;
  u2g_pkg::result_t              res;
  logic                          emit;
  logic                          advance;
  logic [u2g_pkg::CpW-1:0]       shifted;
  logic [1:0]                    pend_dec;

  assign advance      = in_valid_q && (!out_valid_q || glyph_o.ready);
  assign text_i.ready = !in_valid_q || advance;

  assign shifted  = {part_q[u2g_pkg::CpW-7:0], in_byte_q[5:0]};
  assign pend_dec = pend_q - 2'd1;

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    emit   = 1'b0;
    res    = u2g_pkg::map_glyph(u2g_pkg::QMARK_CP, 1'b1);
    if (pend_q != 2'd0) begin
      pend_d = pend_dec;
      if (pend_dec == 2'd0) begin
        emit   = 1'b1;
        part_d = '0;
        res    = u2g_pkg::map_glyph(shifted, 1'b0);
      end else begin
        part_d = shifted;
      end
    end else if (!in_byte_q[7]) begin
      emit = 1'b1;
      res  = u2g_pkg::map_glyph({13'd0, in_byte_q}, 1'b0);
    end else if ((in_byte_q & u2g_pkg::LEAD3_MASK) == u2g_pkg::LEAD2_CODE) begin
      pend_d = 2'd1;
      part_d = {16'd0, in_byte_q[4:0]};
    end else if ((in_byte_q & u2g_pkg::LEAD4_MASK_HI) == u2g_pkg::LEAD3_CODE) begin
      pend_d = 2'd2;
      part_d = {17'd0, in_byte_q[3:0]};
    end else if ((in_byte_q & u2g_pkg::LEAD4_MASK) == u2g_pkg::LEAD4_CODE) begin
      pend_d = 2'd3;
      part_d = {18'd0, in_byte_q[2:0]};
    end else begin
      emit = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (glyph_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      part_q      <= '0;
    end else begin
      if (text_i.ready) begin
        in_valid_q <= text_i.valid;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        pend_q <= pend_d;
        part_q <= part_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      in_byte_q <= text_i.text_byte;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign glyph_o.valid       = out_valid_q;
  assign glyph_o.code_point  = out_q.code_point;
  assign glyph_o.glyph_set   = out_q.glyph_set;
  assign glyph_o.glyph_index = out_q.glyph_index;
  assign glyph_o.glyph_found = out_q.glyph_found;
  assign glyph_o.bad_lead    = out_q.bad_lead;

endmodule

[hdl/u2g_checker.sv]
// Port-level checks for the UTF-8 glyph index decoder, bound to the top level.
`include "assert_macros.svh"

module u2g_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         valid_i,
  input logic                         ready_i,
  input logic [u2g_pkg::CpW-1:0]      code_point_i,
  input logic [u2g_pkg::SetW-1:0]     glyph_set_i,
  input logic [u2g_pkg::IndexW-1:0]   glyph_index_i,
  input logic                         glyph_found_i,
  input logic                         bad_lead_i
);

  `U2G_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !valid_i, "item valid during reset")
  `U2G_ASSERT(a_hold_valid, clk_i, rst_ni, valid_i && !ready_i |=> valid_i, "item dropped while stalled")
  `U2G_ASSERT(a_hold_data, clk_i, rst_ni, valid_i && !ready_i |=> $stable(code_point_i) && $stable(glyph_index_i) && $stable(glyph_set_i), "item changed while stalled")
  `U2G_ASSERT(a_bad_lead_qmark, clk_i, rst_ni, valid_i && bad_lead_i |-> code_point_i == u2g_pkg::QMARK_CP && glyph_index_i == u2g_pkg::QMARK_INDEX && glyph_set_i == u2g_pkg::GLYPH_ASCII && glyph_found_i, "bad lead not mapped to question mark")
  `U2G_ASSERT(a_fallback_space, clk_i, rst_ni, valid_i && !glyph_found_i |-> glyph_index_i == '0 && glyph_set_i == u2g_pkg::GLYPH_ASCII, "unmapped point not sent to space")

endmodule

bind utf8_to_glyph_index_decoder_top u2g_checker u_u2g_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (glyph_o.valid),
  .ready_i       (glyph_o.ready),
  .code_point_i  (glyph_o.code_point),
  .glyph_set_i   (glyph_o.glyph_set),
  .glyph_index_i (glyph_o.glyph_index),
  .glyph_found_i (glyph_o.glyph_found),
  .bad_lead_i    (glyph_o.bad_lead)
);
